/* rtl/wbq_pkg.sv */
package wbq_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_HALF_WIDTH    = 3'd0;
  localparam logic [2:0] REG_QUAD_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_WAVE_DISTANCE = 3'd2;
  localparam logic [2:0] REG_WAVE_PHASE    = 3'd3;
  localparam logic [2:0] REG_BASE_RGB      = 3'd4;
  localparam logic [2:0] REG_FADE_ALPHA    = 3'd5;
  localparam logic [2:0] REG_BACK_FACES    = 3'd6;
  localparam logic [2:0] REG_U_STEP        = 3'd7;

  localparam int unsigned SINE_TABLE_SIZE = 256;
  localparam logic [7:0]  COS_OFFSET      = 8'd64;

  // quarter wave of sin * 16384, rounded
  localparam logic [14:0] QUARTER_SINE [0:64] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,
    15'd2801,  15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,
    15'd5520,  15'd5897,  15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,
    15'd8076,  15'd8423,  15'd8765,  15'd9102,  15'd9434,  15'd9760,  15'd10080,
    15'd10394, 15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
    15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623, 15'd13842,
    15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978, 15'd15137,
    15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364,
    15'd16379, 15'd16384
  };

  // configuration register file contents
  typedef struct packed {
    logic [19:0] half_width;
    logic [19:0] quad_height;
    logic [19:0] wave_distance;
    logic [7:0]  wave_phase;
    logic [23:0] base_rgb;
    logic [7:0]  fade_alpha;
    logic        back_faces;
    logic [16:0] u_step;
  } cfg_t;

  // sine value in sign and magnitude form
  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } sine_t;

  // per particle geometry leaving the arithmetic pipeline
  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [23:0] xoff;
    logic signed [23:0] zoff;
    logic signed [23:0] wx;
    logic signed [23:0] wz;
    logic [21:0]        top;
    logic [23:0]        u0;
    logic [23:0]        u1;
    logic signed [15:0] fs;
    logic signed [15:0] fc;
    logic               fin;
  } geo_t;

  // the four corners of one quad, ready for emission
  typedef struct packed {
    logic [23:0]        x_tl;
    logic [23:0]        x_tr;
    logic [23:0]        x_br;
    logic [23:0]        x_bl;
    logic [23:0]        z_tl;
    logic [23:0]        z_tr;
    logic [23:0]        z_br;
    logic [23:0]        z_bl;
    logic [23:0]        y_top;
    logic [23:0]        y_bot;
    logic [23:0]        u0;
    logic [23:0]        u1;
    logic signed [15:0] fs;
    logic signed [15:0] fc;
    logic               fin;
  } corner_t;

  // sine rom lookup, full wave rebuilt from the quarter wave
  function automatic sine_t sine_lookup(input logic [7:0] idx);
    sine_t      res;
    logic [6:0] q;
    q = idx[6] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
    res.mag = QUARTER_SINE[q];
    res.neg = idx[7];
    return res;
  endfunction

  // sign and magnitude to two's complement
  function automatic logic signed [15:0] sine_value(input sine_t s);
    logic signed [15:0] m;
    m = $signed({1'b0, s.mag});
    return s.neg ? -m : m;
  endfunction

endpackage

/* rtl/wbq_cfg.sv */
module wbq_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output wbq_pkg::cfg_t  cfg
);
  import wbq_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width    <= 20'd8192;
      cfg_r.quad_height   <= 20'd16384;
      cfg_r.wave_distance <= 20'd2560;
      cfg_r.wave_phase    <= 8'd0;
      cfg_r.base_rgb      <= 24'hFFFFFF;
      cfg_r.fade_alpha    <= 8'hFF;
      cfg_r.back_faces    <= 1'b0;
      cfg_r.u_step        <= 17'd65536;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HALF_WIDTH:    cfg_r.half_width    <= pwdata[19:0];
        REG_QUAD_HEIGHT:   cfg_r.quad_height   <= pwdata[19:0];
        REG_WAVE_DISTANCE: cfg_r.wave_distance <= pwdata[19:0];
        REG_WAVE_PHASE:    cfg_r.wave_phase    <= pwdata[7:0];
        REG_BASE_RGB:      cfg_r.base_rgb      <= pwdata[23:0];
        REG_FADE_ALPHA:    cfg_r.fade_alpha    <= pwdata[7:0];
        REG_BACK_FACES:    cfg_r.back_faces    <= pwdata[0];
        REG_U_STEP:        cfg_r.u_step        <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_HALF_WIDTH:    prdata = {12'd0, cfg_r.half_width};
      REG_QUAD_HEIGHT:   prdata = {12'd0, cfg_r.quad_height};
      REG_WAVE_DISTANCE: prdata = {12'd0, cfg_r.wave_distance};
      REG_WAVE_PHASE:    prdata = {24'd0, cfg_r.wave_phase};
      REG_BASE_RGB:      prdata = {8'd0, cfg_r.base_rgb};
      REG_FADE_ALPHA:    prdata = {24'd0, cfg_r.fade_alpha};
      REG_BACK_FACES:    prdata = {31'd0, cfg_r.back_faces};
      REG_U_STEP:        prdata = {15'd0, cfg_r.u_step};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/wbq_geom.sv */
module wbq_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  wbq_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0]        in_particle_scale,
  input  logic [7:0]         in_facing_index,
  input  logic [7:0]         in_sway_rotation,
  input  logic [7:0]         in_sway_start,
  input  logic [7:0]         in_image_index,
  input  logic               in_final_particle,
  output logic               geo_valid,
  input  logic               geo_ready,
  output wbq_pkg::geo_t      geo
);
  import wbq_pkg::*;

  // stage advance chain
  logic take1, take2, take3;

  // stage 1: rom lookups, scale and u products
  logic               s1_v_r;
  logic signed [23:0] s1_px_r, s1_py_r, s1_pz_r;
  sine_t              s1_fs_r, s1_fc_r, s1_rs_r, s1_rc_r, s1_wa_r;
  logic [35:0]        s1_sw_r;
  logic [21:0]        s1_top_r;
  logic [23:0]        s1_u0_r;
  logic               s1_fin_r;
  logic [35:0]        s1_sw_nxt;
  logic [35:0]        s1_topp_nxt;
  logic [24:0]        s1_u0p_nxt;

  // stage 2: partial products
  logic               s2_v_r;
  logic signed [23:0] s2_px_r, s2_py_r, s2_pz_r;
  logic [32:0]        s2_xlo_r, s2_xhi_r, s2_zlo_r, s2_zhi_r;
  logic               s2_xneg_r, s2_zneg_r;
  logic [29:0]        s2_wr_r, s2_wc_r;
  logic               s2_wxneg_r, s2_wzneg_r;
  logic signed [15:0] s2_fs_r, s2_fc_r;
  logic [21:0]        s2_top_r;
  logic [23:0]        s2_u0_r, s2_u1_r;
  logic               s2_fin_r;

  // stage 3: offsets, truncated toward zero
  logic               s3_v_r;
  geo_t               s3_r;
  logic [50:0]        xsum_nxt, zsum_nxt;
  logic [49:0]        wxp_nxt, wzp_nxt;
  logic [22:0]        xmag_nxt, zmag_nxt;
  logic [21:0]        wxm_nxt, wzm_nxt;

  assign take3    = !s3_v_r || geo_ready;
  assign take2    = !s2_v_r || take3;
  assign take1    = !s1_v_r || take2;
  assign in_stall = !take1;

  assign s1_sw_nxt   = in_particle_scale * cfg.half_width;
  assign s1_topp_nxt = in_particle_scale * cfg.quad_height;
  assign s1_u0p_nxt  = in_image_index * cfg.u_step;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (take1) s1_v_r <= in_valid;
      if (take2) s2_v_r <= s1_v_r;
      if (take3) s3_v_r <= s2_v_r;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (take1 && in_valid) begin
      s1_px_r  <= in_pos_x;
      s1_py_r  <= in_pos_y;
      s1_pz_r  <= in_pos_z;
      s1_fs_r  <= sine_lookup(in_facing_index);
      s1_fc_r  <= sine_lookup(in_facing_index + COS_OFFSET);
      s1_rs_r  <= sine_lookup(in_sway_rotation);
      s1_rc_r  <= sine_lookup(in_sway_rotation + COS_OFFSET);
      s1_wa_r  <= sine_lookup(cfg.wave_phase + in_sway_start);
      s1_sw_r  <= s1_sw_nxt;
      s1_top_r <= s1_topp_nxt[35:14];
      s1_u0_r  <= s1_u0p_nxt[23:0];
      s1_fin_r <= in_final_particle;
    end
  end

  // stage 2 payload: wide products split in two halves
  always_ff @(posedge clk) begin
    if (take2 && s1_v_r) begin
      s2_px_r    <= s1_px_r;
      s2_py_r    <= s1_py_r;
      s2_pz_r    <= s1_pz_r;
      s2_xlo_r   <= s1_fs_r.mag * s1_sw_r[17:0];
      s2_xhi_r   <= s1_fs_r.mag * s1_sw_r[35:18];
      s2_zlo_r   <= s1_fc_r.mag * s1_sw_r[17:0];
      s2_zhi_r   <= s1_fc_r.mag * s1_sw_r[35:18];
      s2_xneg_r  <= s1_fs_r.neg;
      s2_zneg_r  <= s1_fc_r.neg;
      s2_wr_r    <= s1_wa_r.mag * s1_rs_r.mag;
      s2_wc_r    <= s1_wa_r.mag * s1_rc_r.mag;
      s2_wxneg_r <= s1_wa_r.neg ^ s1_rs_r.neg;
      s2_wzneg_r <= s1_wa_r.neg ^ s1_rc_r.neg;
      s2_fs_r    <= sine_value(s1_fs_r);
      s2_fc_r    <= sine_value(s1_fc_r);
      s2_top_r   <= s1_top_r;
      s2_u0_r    <= s1_u0_r;
      s2_u1_r    <= s1_u0_r + 24'(cfg.u_step);
      s2_fin_r   <= s1_fin_r;
    end
  end

  // stage 3 arithmetic
  assign xsum_nxt = {s2_xhi_r, 18'd0} + {18'd0, s2_xlo_r};
  assign zsum_nxt = {s2_zhi_r, 18'd0} + {18'd0, s2_zlo_r};
  assign xmag_nxt = xsum_nxt[50:28];
  assign zmag_nxt = zsum_nxt[50:28];
  assign wxp_nxt  = s2_wr_r * cfg.wave_distance;
  assign wzp_nxt  = s2_wc_r * cfg.wave_distance;
  assign wxm_nxt  = wxp_nxt[49:28];
  assign wzm_nxt  = wzp_nxt[49:28];

  always_ff @(posedge clk) begin
    if (take3 && s2_v_r) begin
      s3_r.px   <= s2_px_r;
      s3_r.py   <= s2_py_r;
      s3_r.pz   <= s2_pz_r;
      s3_r.xoff <= s2_xneg_r ? -$signed({1'b0, xmag_nxt}) : $signed({1'b0, xmag_nxt});
      s3_r.zoff <= s2_zneg_r ? -$signed({1'b0, zmag_nxt}) : $signed({1'b0, zmag_nxt});
      s3_r.wx   <= s2_wxneg_r ? -$signed({2'b0, wxm_nxt}) : $signed({2'b0, wxm_nxt});
      s3_r.wz   <= s2_wzneg_r ? -$signed({2'b0, wzm_nxt}) : $signed({2'b0, wzm_nxt});
      s3_r.top  <= s2_top_r;
      s3_r.u0   <= s2_u0_r;
      s3_r.u1   <= s2_u1_r;
      s3_r.fs   <= s2_fs_r;
      s3_r.fc   <= s2_fc_r;
      s3_r.fin  <= s2_fin_r;
    end
  end

  assign geo_valid = s3_v_r;
  assign geo       = s3_r;

endmodule

/* rtl/wbq_emit.sv */
module wbq_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  wbq_pkg::cfg_t      cfg,
  input  logic               geo_valid,
  output logic               geo_ready,
  input  wbq_pkg::geo_t      geo,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_y,
  output logic signed [23:0] out_vert_z,
  output logic [23:0]        out_tex_u,
  output logic               out_tex_v,
  output logic [31:0]        out_vert_color,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_z,
  output logic signed [15:0] out_tangent_x,
  output logic signed [15:0] out_tangent_z,
  output logic               out_last_vertex,
  output logic               out_end_of_volume
);
  import wbq_pkg::*;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  // quad buffer
  logic        bv_r;
  corner_t     buf_r;
  corner_t     buf_nxt;
  logic [2:0]  cnt_r;
  logic        emit, last, buf_take, back;
  logic [1:0]  corner;

  // output register
  logic               ov_r;
  logic signed [23:0] ox_r, oy_r, oz_r;
  logic [23:0]        ou_r;
  logic               ov_v_r;
  logic [31:0]        ocol_r;
  logic signed [15:0] onx_r, onz_r, otx_r, otz_r;
  logic               olast_r, oeov_r;

  // selected vertex
  logic [23:0]        vx, vy, vz, vu;
  logic               vtv;

  logic signed [23:0] wx_l, wx_r, wz_l, wz_r;

  assign emit      = bv_r && (!ov_r || !out_stall);
  assign last      = cfg.back_faces ? (cnt_r == 3'd7) : (cnt_r == 3'd3);
  assign buf_take  = !bv_r || (emit && last);
  assign geo_ready = buf_take;
  assign back      = cnt_r[2];
  assign corner    = back ? ~cnt_r[1:0] : cnt_r[1:0];

  // corner positions
  assign wx_l = geo.px - geo.xoff;
  assign wx_r = geo.px + geo.xoff;
  assign wz_l = geo.pz - geo.zoff;
  assign wz_r = geo.pz + geo.zoff;

  always_comb begin
    buf_nxt.x_bl  = wx_l;
    buf_nxt.x_br  = wx_r;
    buf_nxt.x_tl  = wx_l + geo.wx;
    buf_nxt.x_tr  = wx_r + geo.wx;
    buf_nxt.z_bl  = wz_l;
    buf_nxt.z_br  = wz_r;
    buf_nxt.z_tl  = wz_l + geo.wz;
    buf_nxt.z_tr  = wz_r + geo.wz;
    buf_nxt.y_bot = geo.py;
    buf_nxt.y_top = geo.py + $signed({2'b0, geo.top});
    buf_nxt.u0    = geo.u0;
    buf_nxt.u1    = geo.u1;
    buf_nxt.fs    = geo.fs;
    buf_nxt.fc    = geo.fc;
    buf_nxt.fin   = geo.fin;
  end

  // buffer and vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      cnt_r <= 3'd0;
    end else if (buf_take) begin
      bv_r  <= geo_valid;
      cnt_r <= 3'd0;
    end else if (emit) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_take && geo_valid) begin
      buf_r <= buf_nxt;
    end
  end

  // vertex select
  always_comb begin
    case (corner)
      CORNER_TL: begin
        vx = buf_r.x_tl; vy = buf_r.y_top; vz = buf_r.z_tl; vu = buf_r.u0; vtv = 1'b0;
      end
      CORNER_TR: begin
        vx = buf_r.x_tr; vy = buf_r.y_top; vz = buf_r.z_tr; vu = buf_r.u1; vtv = 1'b0;
      end
      CORNER_BR: begin
        vx = buf_r.x_br; vy = buf_r.y_bot; vz = buf_r.z_br; vu = buf_r.u1; vtv = 1'b1;
      end
      CORNER_BL: begin
        vx = buf_r.x_bl; vy = buf_r.y_bot; vz = buf_r.z_bl; vu = buf_r.u0; vtv = 1'b1;
      end
      default: begin
        vx = buf_r.x_bl; vy = buf_r.y_bot; vz = buf_r.z_bl; vu = buf_r.u0; vtv = 1'b1;
      end
    endcase
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (!ov_r || !out_stall) begin
      ov_r <= emit;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      ox_r    <= vx;
      oy_r    <= vy;
      oz_r    <= vz;
      ou_r    <= vu;
      ov_v_r  <= vtv;
      ocol_r  <= {cfg.fade_alpha, cfg.base_rgb};
      onx_r   <= back ? -buf_r.fc : buf_r.fc;
      onz_r   <= back ? buf_r.fs : -buf_r.fs;
      otx_r   <= -buf_r.fs;
      otz_r   <= -buf_r.fc;
      olast_r <= last;
      oeov_r  <= last && buf_r.fin;
    end
  end

  assign out_valid         = ov_r;
  assign out_vert_x        = ox_r;
  assign out_vert_y        = oy_r;
  assign out_vert_z        = oz_r;
  assign out_tex_u         = ou_r;
  assign out_tex_v         = ov_v_r;
  assign out_vert_color    = ocol_r;
  assign out_normal_x      = onx_r;
  assign out_normal_z      = onz_r;
  assign out_tangent_x     = otx_r;
  assign out_tangent_z     = otz_r;
  assign out_last_vertex   = olast_r;
  assign out_end_of_volume = oeov_r;

endmodule

/* rtl/wavy_billboard_quad_expander_top.sv */
// wind-swayed billboard quad expander
// input channel (in_*): one scatter particle per item, taken on in_valid with
// in_stall low; output channel (out_*): one billboard vertex per item, taken on
// out_valid with out_stall low. an apb-style port sets size, wave, colour,
// texture step and back faces; write it only while the block is idle.
// each particle gives four vertices, or eight when back faces are on, the
// last one flagged by out_last_vertex (and out_end_of_volume on the final
// particle of a volume).
// the first vertex of a particle passes through three arithmetic stages and
// the quad buffer into the output register. the single output register
// emits one vertex per cycle while out_stall is low, four per particle or
// eight with back faces; while the quad buffer is emitting, the arithmetic
// stages keep taking particles until full.
// reset clears all valid bits and loads the register reset values.
// a stalled receiver freezes the output register; the quad buffer and then
// each stage fill up in turn before in_stall rises, and nothing is lost.
module wavy_billboard_quad_expander_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0]        in_particle_scale,
  input  logic [7:0]         in_facing_index,
  input  logic [7:0]         in_sway_rotation,
  input  logic [7:0]         in_sway_start,
  input  logic [7:0]         in_image_index,
  input  logic               in_final_particle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_y,
  output logic signed [23:0] out_vert_z,
  output logic [23:0]        out_tex_u,
  output logic               out_tex_v,
  output logic [31:0]        out_vert_color,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_z,
  output logic signed [15:0] out_tangent_x,
  output logic signed [15:0] out_tangent_z,
  output logic               out_last_vertex,
  output logic               out_end_of_volume
);
  import wbq_pkg::*;

  cfg_t cfg;
  geo_t geo;
  logic geo_valid;
  logic geo_ready;

  // configuration registers
  wbq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // particle arithmetic pipeline
  wbq_geom u_geom (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_particle_scale (in_particle_scale),
    .in_facing_index   (in_facing_index),
    .in_sway_rotation  (in_sway_rotation),
    .in_sway_start     (in_sway_start),
    .in_image_index    (in_image_index),
    .in_final_particle (in_final_particle),
    .geo_valid         (geo_valid),
    .geo_ready         (geo_ready),
    .geo               (geo)
  );

  // vertex emission
  wbq_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .geo_valid         (geo_valid),
    .geo_ready         (geo_ready),
    .geo               (geo),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vert_x        (out_vert_x),
    .out_vert_y        (out_vert_y),
    .out_vert_z        (out_vert_z),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_vert_color    (out_vert_color),
    .out_normal_x      (out_normal_x),
    .out_normal_z      (out_normal_z),
    .out_tangent_x     (out_tangent_x),
    .out_tangent_z     (out_tangent_z),
    .out_last_vertex   (out_last_vertex),
    .out_end_of_volume (out_end_of_volume)
  );

endmodule

/* dv/wavy_billboard_quad_expander_top_tb.sv */
`timescale 1ns / 1ps

module wavy_billboard_quad_expander_top_tb;
  import wbq_pkg::*;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          STUCK_LIMIT   = 2000;
  localparam logic [7:0]  QUARTER_TURN  = 8'd64;

  // one scatter particle as driven on the input channel
  typedef struct packed {
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] pos_z;
    logic [15:0] scale;
    logic [7:0]  facing;
    logic [7:0]  rotation;
    logic [7:0]  start;
    logic [7:0]  image;
    logic        final_p;
  } particle_t;

  // one billboard vertex as seen on the result channel
  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [23:0] u;
    logic        v;
    logic [31:0] color;
    logic [15:0] nx;
    logic [15:0] nz;
    logic [15:0] tx;
    logic [15:0] tz;
    logic        last;
    logic        eov;
  } vertex_t;

  // local copy of the register file
  typedef struct packed {
    logic [19:0] half_width;
    logic [19:0] quad_height;
    logic [19:0] wave_distance;
    logic [7:0]  wave_phase;
    logic [23:0] base_rgb;
    logic [7:0]  fade_alpha;
    logic        back_faces;
    logic [16:0] u_step;
  } knobs_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic signed [23:0] in_pos_z = '0;
  logic [15:0]        in_particle_scale = '0;
  logic [7:0]         in_facing_index = '0;
  logic [7:0]         in_sway_rotation = '0;
  logic [7:0]         in_sway_start = '0;
  logic [7:0]         in_image_index = '0;
  logic               in_final_particle = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] out_vert_x;
  logic signed [23:0] out_vert_y;
  logic signed [23:0] out_vert_z;
  logic [23:0]        out_tex_u;
  logic               out_tex_v;
  logic [31:0]        out_vert_color;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_z;
  logic signed [15:0] out_tangent_x;
  logic signed [15:0] out_tangent_z;
  logic               out_last_vertex;
  logic               out_end_of_volume;

  wavy_billboard_quad_expander_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_particle_scale (in_particle_scale),
    .in_facing_index   (in_facing_index),
    .in_sway_rotation  (in_sway_rotation),
    .in_sway_start     (in_sway_start),
    .in_image_index    (in_image_index),
    .in_final_particle (in_final_particle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vert_x        (out_vert_x),
    .out_vert_y        (out_vert_y),
    .out_vert_z        (out_vert_z),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_vert_color    (out_vert_color),
    .out_normal_x      (out_normal_x),
    .out_normal_z      (out_normal_z),
    .out_tangent_x     (out_tangent_x),
    .out_tangent_z     (out_tangent_z),
    .out_last_vertex   (out_last_vertex),
    .out_end_of_volume (out_end_of_volume)
  );

  // quarter wave of sin * 16384, rounded
  int quarter_wave [0:64] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590,
    3981, 4370, 4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366,
    7723, 8076, 8423, 8765, 9102, 9434, 9760, 10080, 10394, 10702,
    11003, 11297, 11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
    13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978, 15137, 15286,
    15426, 15557, 15679, 15791, 15893, 15986, 16069, 16143, 16207, 16261,
    16305, 16340, 16364, 16379, 16384
  };

  knobs_t knobs = '{
    half_width: 20'd8192, quad_height: 20'd16384, wave_distance: 20'd2560,
    wave_phase: 8'd0, base_rgb: 24'hFFFFFF, fade_alpha: 8'hFF,
    back_faces: 1'b0, u_step: 17'd65536
  };

  particle_t particle_q [$];
  vertex_t   vertex_q [$];
  particle_t presented = '0;
  int        idle_pct = 23;
  int        error_count = 0;
  int        particles_in = 0;
  int        vertices_out = 0;
  int        settings_count = 1;
  int        stuck = 0;

  always #4 clk = ~clk;

  // full wave from the quarter table
  function automatic int sine_of(logic [7:0] idx);
    int r;
    r = int'(idx[5:0]);
    case (idx[7:6])
      2'd0: return quarter_wave[r];
      2'd1: return quarter_wave[64 - r];
      2'd2: return -quarter_wave[r];
      default: return -quarter_wave[64 - r];
    endcase
  endfunction

  // signed times unsigned, >> 28, truncated toward zero
  function automatic longint scaled_trunc(longint a, longint unsigned b);
    longint unsigned mag;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    mag = (mag * b) >> 28;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // work out the vertices of one particle's quad
  function automatic void expand_particle(particle_t p);
    int          fs, fc, wamp, cnt, c, nx, nz;
    longint      xoff, zoff, top, wx, wz, x, y, z, side;
    longint unsigned sw;
    logic [63:0] prod;
    logic [23:0] u0, u1;
    logic [7:0]  idx;
    logic        is_top, back;
    vertex_t     v;
    fs = sine_of(p.facing);
    idx = p.facing + QUARTER_TURN;
    fc = sine_of(idx);
    sw = 64'(p.scale) * 64'(knobs.half_width);
    xoff = scaled_trunc(fs, sw);
    zoff = scaled_trunc(fc, sw);
    prod = (64'(p.scale) * 64'(knobs.quad_height)) >> 14;
    top = longint'(prod);
    idx = knobs.wave_phase + p.start;
    wamp = sine_of(idx);
    wx = scaled_trunc(longint'(wamp) * sine_of(p.rotation), 64'(knobs.wave_distance));
    idx = p.rotation + QUARTER_TURN;
    wz = scaled_trunc(longint'(wamp) * sine_of(idx), 64'(knobs.wave_distance));
    prod = 64'(p.image) * 64'(knobs.u_step);
    u0 = prod[23:0];
    prod = 64'(u0) + 64'(knobs.u_step);
    u1 = prod[23:0];
    cnt = knobs.back_faces ? 8 : 4;
    for (int k = 0; k < cnt; k++) begin
      back = (k >= 4);
      c = back ? 7 - k : k;
      side = (c == 1 || c == 2) ? 1 : -1;
      is_top = (c < 2);
      x = longint'($signed(p.pos_x));
      x += side * xoff;
      y = longint'($signed(p.pos_y));
      z = longint'($signed(p.pos_z));
      z += side * zoff;
      if (is_top) begin
        x += wx;
        y += top;
        z += wz;
      end
      nx = back ? -fc : fc;
      nz = back ? fs : -fs;
      v.x = x[23:0];
      v.y = y[23:0];
      v.z = z[23:0];
      v.u = (side < 0) ? u0 : u1;
      v.v = !is_top;
      v.color = {knobs.fade_alpha, knobs.base_rgb};
      v.nx = nx[15:0];
      v.nz = nz[15:0];
      nx = -fs;
      nz = -fc;
      v.tx = nx[15:0];
      v.tz = nz[15:0];
      v.last = (k == cnt - 1);
      v.eov = v.last && p.final_p;
      vertex_q.push_back(v);
    end
  endfunction

  function automatic void note_reg_write(logic [2:0] idx, logic [31:0] d);
    case (idx)
      REG_HALF_WIDTH:    knobs.half_width = d[19:0];
      REG_QUAD_HEIGHT:   knobs.quad_height = d[19:0];
      REG_WAVE_DISTANCE: knobs.wave_distance = d[19:0];
      REG_WAVE_PHASE:    knobs.wave_phase = d[7:0];
      REG_BASE_RGB:      knobs.base_rgb = d[23:0];
      REG_FADE_ALPHA:    knobs.fade_alpha = d[7:0];
      REG_BACK_FACES:    knobs.back_faces = d[0];
      REG_U_STEP:        knobs.u_step = d[16:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic particle_t mk(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                                   logic [15:0] s, logic [7:0] f, logic [7:0] r,
                                   logic [7:0] st, logic [7:0] im, logic fin);
    particle_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    p.scale = s;
    p.facing = f;
    p.rotation = r;
    p.start = st;
    p.image = im;
    p.final_p = fin;
    return p;
  endfunction

  // positions lean towards the wrap points now and then
  function automatic logic [23:0] pick_pos();
    case ($urandom_range(7))
      0: return 24'h7FFFFF - 24'($urandom_range(255));
      1: return 24'h800000 + 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic particle_t random_particle();
    logic [15:0] s;
    case ($urandom_range(9))
      0: s = 16'h0000;
      1: s = 16'hFFFF;
      default: s = 16'($urandom);
    endcase
    return mk(pick_pos(), pick_pos(), pick_pos(), s, 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), $urandom_range(4) == 0);
  endfunction

  // register words, upper junk bits included
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    note_reg_write(idx, d);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] hw, logic [31:0] qh, logic [31:0] wd, logic [31:0] ph,
                         logic [31:0] rgb, logic [31:0] al, logic [31:0] bf, logic [31:0] us);
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_QUAD_HEIGHT, qh);
    write_reg(REG_WAVE_DISTANCE, wd);
    write_reg(REG_WAVE_PHASE, ph);
    write_reg(REG_BASE_RGB, rgb);
    write_reg(REG_FADE_ALPHA, al);
    write_reg(REG_BACK_FACES, bf);
    write_reg(REG_U_STEP, us);
    settings_count++;
  endtask

  // hold the sender until every vertex is back, then let the pipe drain
  task automatic settle();
    while (particle_q.size() != 0 || in_valid || vertex_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // particle driver
  always @(posedge clk) begin : feed
    particle_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_particle(presented);
        particles_in++;
      end
      if (!in_valid || !in_stall) begin
        if (particle_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = particle_q[0];
          particle_q.delete(0);
          presented <= nxt;
          in_pos_x <= nxt.pos_x;
          in_pos_y <= nxt.pos_y;
          in_pos_z <= nxt.pos_z;
          in_particle_scale <= nxt.scale;
          in_facing_index <= nxt.facing;
          in_sway_rotation <= nxt.rotation;
          in_sway_start <= nxt.start;
          in_image_index <= nxt.image;
          in_final_particle <= nxt.final_p;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // vertex monitor and receiver stalls
  always @(posedge clk) begin : watch
    vertex_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_vert_x;
      got.y = out_vert_y;
      got.z = out_vert_z;
      got.u = out_tex_u;
      got.v = out_tex_v;
      got.color = out_vert_color;
      got.nx = out_normal_x;
      got.nz = out_normal_z;
      got.tx = out_tangent_x;
      got.tz = out_tangent_z;
      got.last = out_last_vertex;
      got.eov = out_end_of_volume;
      if (vertex_q.size() == 0) begin
        $error("vertex with no particle outstanding: x %0h y %0h", got.x, got.y);
        error_count++;
      end else begin
        want = vertex_q[0];
        vertex_q.delete(0);
        vertices_out++;
        compare_field("vert_x", 32'(want.x), 32'(got.x));
        compare_field("vert_y", 32'(want.y), 32'(got.y));
        compare_field("vert_z", 32'(want.z), 32'(got.z));
        compare_field("tex_u", 32'(want.u), 32'(got.u));
        compare_field("tex_v", 32'(want.v), 32'(got.v));
        compare_field("vert_color", want.color, got.color);
        compare_field("normal_x", 32'(want.nx), 32'(got.nx));
        compare_field("normal_z", 32'(want.nz), 32'(got.nz));
        compare_field("tangent_x", 32'(want.tx), 32'(got.tx));
        compare_field("tangent_z", 32'(want.tz), 32'(got.tz));
        compare_field("last_vertex", 32'(want.last), 32'(got.last));
        compare_field("end_of_volume", 32'(want.eov), 32'(got.eov));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);
  end

  // watchdog on cycles with no progress anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck == STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : scenario
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: field extremes and each facing quadrant
    particle_q.push_back(mk(24'h0, 24'h0, 24'h0, 16'h0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    particle_q.push_back(mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF,
                            8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    particle_q.push_back(mk(24'h800000, 24'h800000, 24'h800000, 16'hFFFF,
                            8'd64, 8'd64, 8'd64, 8'd255, 1'b0));
    particle_q.push_back(mk(24'h001234, 24'hFFF000, 24'h0ABCDE, 16'h4000,
                            8'd128, 8'd128, 8'd128, 8'd1, 1'b1));
    particle_q.push_back(mk(24'hFEDCBA, 24'h000100, 24'h555555, 16'h8000,
                            8'd192, 8'd192, 8'd192, 8'd7, 1'b0));
    particle_q.push_back(mk(24'hAAAAAA, 24'h555555, 24'hFFFFFF, 16'h2000,
                            8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    particle_q.push_back(mk(24'h000001, 24'h000002, 24'h000003, 16'h0000,
                            8'd32, 8'd96, 8'd160, 8'd128, 1'b0));
    particle_q.push_back(mk(24'h7FFF00, 24'h7FFFFF, 24'h800100, 16'hC000,
                            8'd63, 8'd65, 8'd127, 8'd3, 1'b1));
    settle();

    // every register at its top, upper junk bits set, back faces on
    set_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    particle_q.push_back(mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF,
                            8'd32, 8'd0, 8'd1, 8'd255, 1'b1));
    particle_q.push_back(mk(24'h800000, 24'h800000, 24'h800000, 16'hFFFF,
                            8'd160, 8'd200, 8'd0, 8'd128, 1'b0));
    particle_q.push_back(mk(24'h0, 24'h0, 24'h0, 16'h4000,
                            8'd96, 8'd224, 8'd65, 8'd0, 1'b1));
    particle_q.push_back(mk(24'h123456, 24'h876543, 24'h0F0F0F, 16'h0001,
                            8'd224, 8'd32, 8'd191, 8'd254, 1'b0));
    particle_q.push_back(mk(24'hFFFFFF, 24'h000000, 24'h7FFFFF, 16'hFFFF,
                            8'd64, 8'd128, 8'd128, 8'd1, 1'b1));
    settle();

    // every register cleared, zero texture step
    set_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    particle_q.push_back(mk(24'h7FFFFF, 24'h800000, 24'h0, 16'hFFFF,
                            8'd17, 8'd99, 8'd200, 8'd255, 1'b1));
    particle_q.push_back(mk(24'h654321, 24'hABCDEF, 24'h13579B, 16'h1234,
                            8'd240, 8'd12, 8'd33, 8'd77, 1'b0));
    particle_q.push_back(mk(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 16'h8001,
                            8'd200, 8'd250, 8'd5, 8'd9, 1'b1));
    settle();

    // random register settings, each phase split by a full drain
    for (int ph = 0; ph < 6; ph++) begin
      set_all(pick_word(), pick_word(), pick_word(), pick_word(),
              pick_word(), pick_word(), $urandom, pick_word());
      idle_pct = (ph == 2) ? 0 : 23;
      repeat (23) particle_q.push_back(random_particle());
      settle();
      repeat (23) particle_q.push_back(random_particle());
      settle();
    end

    $display("covered %0d particles giving %0d vertices over %0d register settings",
             particles_in, vertices_out, settings_count);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
rtl/wbq_pkg.sv
rtl/wbq_cfg.sv
rtl/wbq_geom.sv
rtl/wbq_emit.sv
rtl/wavy_billboard_quad_expander_top.sv
dv/wavy_billboard_quad_expander_top_tb.sv
